FILE: rtl/wavhc_pkg.sv
// Shared constants, codes and types of the WAV header checker.
package wavhc_pkg;

    // Request queue between the front and the parser
    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_TAG  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAMES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAMES  = 3'd5;

    localparam logic [15:0] RST_FORMAT_TAG  = 16'd1;
    localparam logic [15:0] RST_CHANNELS    = 16'd1;
    localparam logic [31:0] RST_SAMPLE_RATE = 32'd24000;
    localparam logic [15:0] RST_BITS        = 16'd16;
    localparam logic [30:0] RST_MIN_FRAMES  = 31'd24000;
    localparam logic [30:0] RST_MAX_FRAMES  = 31'd1440000;

    // Chunk tags as they assemble little-endian
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_HDR   = 3'd1;
    localparam logic [2:0] ST_BAD_FMT   = 3'd2;
    localparam logic [2:0] ST_TOO_SHORT = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;

    // Parser state at the end of a file, handed to the result stage
    typedef struct packed {
        logic        hdr_fail;
        logic [15:0] format_tag;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [15:0] bits;
        logic [31:0] data_len;
    } t_snap;

endpackage

FILE: rtl/wavhc_front.sv
// Input stage: accepts byte requests into a short queue ahead of the parser.
module wavhc_front #(
    parameter int QUEUE_DEPTH = wavhc_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_file_byte,
    input  logic       i_last_byte,
    output logic       o_q_valid,
    output logic [7:0] o_q_byte,
    output logic       o_q_last,
    input  logic       i_q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [8:0]       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;

    assign o_ready   = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_byte  = r_mem[r_rd_ptr][7:0];
    assign o_q_last  = r_mem[r_rd_ptr][8];
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_pop;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= {i_last_byte, i_file_byte};
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count over depth");

    a_push_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

    a_empty_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !pop)
        else $error("pop from empty queue");

endmodule

FILE: rtl/wavhc_parse.sv
// Chunk walker: header check, fmt capture, data length, skip and pad.
module wavhc_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  logic [7:0]        i_q_byte,
    input  logic              i_q_last,
    output logic              o_q_pop,
    output logic              o_snap_valid,
    input  logic              i_snap_ready,
    output wavhc_pkg::t_snap  o_snap
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_CHDR   = 3'd1;
    localparam logic [2:0] PH_FMT    = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_PAD    = 3'd4;
    localparam logic [2:0] PH_SINK   = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_count, n_count;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic        r_bad, n_bad;
    logic [63:0] r_stage, n_stage;
    logic [15:0] r_fmt, n_fmt;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic [31:0] r_dlen, n_dlen;

    logic [31:0] count_inc;
    logic [31:0] tag_shift;
    logic [31:0] len_shift;
    logic        take;

    // a last byte needs the result stage free; other bytes always go
    assign o_q_pop      = i_q_valid && (!i_q_last || i_snap_ready);
    assign take         = o_q_pop;
    assign o_snap_valid = take && i_q_last;

    assign count_inc = r_count + 32'd1;
    assign tag_shift = {i_q_byte, r_tag[31:8]};
    assign len_shift = {i_q_byte, r_len[31:8]};

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_tag   = r_tag;
        n_len   = r_len;
        n_bad   = r_bad;
        n_stage = r_stage;
        n_fmt   = r_fmt;
        n_chan  = r_chan;
        n_rate  = r_rate;
        n_bits  = r_bits;
        n_dlen  = r_dlen;
        unique case (r_phase)
            PH_HEADER: begin
                n_tag = tag_shift;
                if (r_count == 32'd3 && tag_shift != wavhc_pkg::TAG_RIFF) begin
                    n_bad = 1'b1;
                end
                if (r_count == 32'd11 && tag_shift != wavhc_pkg::TAG_WAVE) begin
                    n_bad = 1'b1;
                end
                n_count = count_inc;
                if (count_inc == 32'd12) begin
                    n_count = '0;
                    n_phase = n_bad ? PH_SINK : PH_CHDR;
                end
            end
            PH_CHDR: begin
                if (r_count < 32'd4) begin
                    n_tag = tag_shift;
                end else begin
                    n_len = len_shift;
                end
                n_count = count_inc;
                if (count_inc == 32'd8) begin
                    n_count = '0;
                    if (r_tag == wavhc_pkg::TAG_FMT) begin
                        n_stage = '0;
                        n_phase = PH_FMT;
                    end else begin
                        if (r_tag == wavhc_pkg::TAG_DATA) begin
                            n_dlen = len_shift;
                        end
                        n_phase = PH_SKIP;
                    end
                    // empty body: next chunk header follows at once
                    if (len_shift == '0) begin
                        n_phase = PH_CHDR;
                    end
                end
            end
            PH_FMT: begin
                if (r_count < 32'd8) begin
                    n_stage[{r_count[2:0], 3'b000} +: 8] = i_q_byte;
                end else if (r_count == 32'd14) begin
                    n_tag = {24'd0, i_q_byte};
                end else if (r_count == 32'd15) begin
                    n_fmt  = r_stage[15:0];
                    n_chan = r_stage[31:16];
                    n_rate = r_stage[63:32];
                    n_bits = {i_q_byte, r_tag[7:0]};
                end
                n_count = count_inc;
                if (count_inc == r_len) begin
                    n_count = '0;
                    n_phase = r_len[0] ? PH_PAD : PH_CHDR;
                end
            end
            PH_SKIP: begin
                n_count = count_inc;
                if (count_inc == r_len) begin
                    n_count = '0;
                    n_phase = r_len[0] ? PH_PAD : PH_CHDR;
                end
            end
            PH_PAD: begin
                n_count = '0;
                n_phase = PH_CHDR;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_snap.hdr_fail    = (n_phase == PH_HEADER) || n_bad;
        o_snap.format_tag  = n_fmt;
        o_snap.channels    = n_chan;
        o_snap.sample_rate = n_rate;
        o_snap.bits        = n_bits;
        o_snap.data_len    = n_dlen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (take && i_q_last)) begin
            r_phase <= PH_HEADER;
            r_count <= '0;
            r_tag   <= '0;
            r_len   <= '0;
            r_bad   <= 1'b0;
            r_stage <= '0;
            r_fmt   <= '0;
            r_chan  <= '0;
            r_rate  <= '0;
            r_bits  <= '0;
            r_dlen  <= '0;
        end else if (take) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_tag   <= n_tag;
            r_len   <= n_len;
            r_bad   <= n_bad;
            r_stage <= n_stage;
            r_fmt   <= n_fmt;
            r_chan  <= n_chan;
            r_rate  <= n_rate;
            r_bits  <= n_bits;
            r_dlen  <= n_dlen;
        end
    end

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_SINK)
        else $error("parser phase out of range");

    a_bad_sinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bad && r_phase != PH_HEADER) |-> (r_phase == PH_SINK))
        else $error("bad header did not sink");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_snap_valid |=> (r_phase == PH_HEADER && r_count == '0))
        else $error("parser not cleared after last byte");

endmodule

FILE: rtl/wavhc_result.sv
// Result stage: configuration registers, status decision and output register.
module wavhc_result (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wavhc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wavhc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_snap_valid,
    output logic                            o_snap_ready,
    input  wavhc_pkg::t_snap                i_snap,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [2:0]                      o_check_status,
    output logic [30:0]                     o_frame_count
);

    logic [15:0] r_want_fmt;
    logic [15:0] r_want_chan;
    logic [31:0] r_want_rate;
    logic [15:0] r_want_bits;
    logic [30:0] r_min_frames;
    logic [30:0] r_max_frames;

    wavhc_pkg::t_snap r_snap;
    logic             r_snap_v;
    logic             r_o_valid;
    logic [2:0]       r_status, n_status;
    logic [30:0]      r_frames, n_frames;
    logic             out_free;
    logic             snap_move;
    logic             fmt_mismatch;

    assign out_free     = !r_o_valid || i_ready;
    assign snap_move    = r_snap_v && out_free;
    assign o_snap_ready = !r_snap_v || snap_move;

    assign o_valid        = r_o_valid;
    assign o_check_status = r_status;
    assign o_frame_count  = r_frames;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_want_fmt   <= wavhc_pkg::RST_FORMAT_TAG;
            r_want_chan  <= wavhc_pkg::RST_CHANNELS;
            r_want_rate  <= wavhc_pkg::RST_SAMPLE_RATE;
            r_want_bits  <= wavhc_pkg::RST_BITS;
            r_min_frames <= wavhc_pkg::RST_MIN_FRAMES;
            r_max_frames <= wavhc_pkg::RST_MAX_FRAMES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wavhc_pkg::CFG_FORMAT_TAG:  r_want_fmt   <= i_cfg_data[15:0];
                wavhc_pkg::CFG_CHANNELS:    r_want_chan  <= i_cfg_data[15:0];
                wavhc_pkg::CFG_SAMPLE_RATE: r_want_rate  <= i_cfg_data[31:0];
                wavhc_pkg::CFG_BITS:        r_want_bits  <= i_cfg_data[15:0];
                wavhc_pkg::CFG_MIN_FRAMES:  r_min_frames <= i_cfg_data[30:0];
                wavhc_pkg::CFG_MAX_FRAMES:  r_max_frames <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    assign fmt_mismatch = (r_snap.format_tag != r_want_fmt) ||
                          (r_snap.channels != r_want_chan) ||
                          (r_snap.sample_rate != r_want_rate) ||
                          (r_snap.bits != r_want_bits) ||
                          (r_snap.data_len == '0);

    always_comb begin
        n_frames = r_snap.data_len[31:1];
        priority if (r_snap.hdr_fail) begin
            n_status = wavhc_pkg::ST_BAD_HDR;
        end else if (fmt_mismatch) begin
            n_status = wavhc_pkg::ST_BAD_FMT;
        end else if (n_frames < r_min_frames) begin
            n_status = wavhc_pkg::ST_TOO_SHORT;
        end else if (n_frames > r_max_frames) begin
            n_status = wavhc_pkg::ST_TOO_LONG;
        end else begin
            n_status = wavhc_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_snap_valid) begin
                r_snap_v <= 1'b1;
            end else if (snap_move) begin
                r_snap_v <= 1'b0;
            end
            if (snap_move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_snap_valid) begin
            r_snap <= i_snap;
        end
        if (snap_move) begin
            r_status <= n_status;
            r_frames <= n_frames;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_snap_valid |-> o_snap_ready)
        else $error("snapshot written while occupied");

    a_move_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        snap_move |=> (r_o_valid && r_status == $past(n_status)))
        else $error("result not presented after move");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_status <= wavhc_pkg::ST_TOO_LONG))
        else $error("status code out of range");

endmodule

FILE: rtl/wav_header_checker.sv
// WAV header checker top level: queue front, chunk parser, result stage.
// Throughput: one file byte per cycle; a last byte waits only while the output and
//   snapshot registers both hold a status, and the queue then fills behind it.
// o_valid rises after the last byte has passed the queue, then the snapshot register.
// Reset (synchronous, i_rst_n low): empties queue and output, parser to the header phase,
//   configuration registers to their defaults.
module wav_header_checker #(
    parameter int QUEUE_DEPTH = wavhc_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // byte requests
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [7:0]                       i_file_byte,
    input  logic                             i_last_byte,
    // status requests, one per file
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [2:0]                       o_check_status,
    output logic [30:0]                      o_frame_count,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [wavhc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wavhc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // queue to parser
    logic       q_valid;
    logic [7:0] q_byte;
    logic       q_last;
    logic       q_pop;

    // parser to result stage: state captured at the last byte of a file
    logic             snap_valid;
    logic             snap_ready;
    wavhc_pkg::t_snap snap;

    // Front: takes byte requests whenever the queue has room, so the source
    // never waits on the parser unless the queue is full.
    wavhc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_file_byte (i_file_byte),
        .i_last_byte (i_last_byte),
        .o_q_valid   (q_valid),
        .o_q_byte    (q_byte),
        .o_q_last    (q_last),
        .i_q_pop     (q_pop)
    );

    // Parser: one byte per cycle through header, chunk header, fmt body, skipped body
    // and pad, a last byte only with the result stage free, then clears itself.
    wavhc_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_byte     (q_byte),
        .i_q_last     (q_last),
        .o_q_pop      (q_pop),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    // Result: compares the captured format against the configuration,
    // ranks the status (header, format/no data, short, long) and registers it.
    wavhc_result u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_snap_valid   (snap_valid),
        .o_snap_ready   (snap_ready),
        .i_snap         (snap),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_check_status (o_check_status),
        .o_frame_count  (o_frame_count)
    );

endmodule
